[rtl/ipv4rx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipv4rx_pkg;

	localparam int unsigned LINK_HEADER_BYTES = 14;

	localparam int unsigned POS_W = 7;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] POS_IP_START = POS_W'(LINK_HEADER_BYTES);

	localparam int unsigned SUM_W = 21;

	localparam logic [POS_W-1:0] IP_OFF_PROTO   = POS_W'(9);
	localparam logic [POS_W-1:0] IP_OFF_CSUM_HI = POS_W'(10);
	localparam logic [POS_W-1:0] IP_OFF_CSUM_LO = POS_W'(11);
	localparam logic [POS_W-1:0] PORT_OFF_HI    = POS_W'(2);
	localparam logic [POS_W-1:0] PORT_OFF_LO    = POS_W'(3);

	localparam logic [7:0] PROTO_TCP = 8'd6;

	localparam logic [2:0] DROP_NONE      = 3'd0;
	localparam logic [2:0] DROP_CHECKSUM  = 3'd1;
	localparam logic [2:0] DROP_NOT_TCP   = 3'd2;
	localparam logic [2:0] DROP_PORT      = 3'd3;
	localparam logic [2:0] DROP_TOO_SHORT = 3'd4;

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_SEL_LOCAL_PORT = 1'b0;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] reason;
	} verdict_t;

endpackage

`default_nettype wire

[rtl/ipv4rx_apb.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_apb
	import ipv4rx_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output logic      [15:0]        local_port
);

	logic [15:0] local_port_q;
	logic        sel_port;

	assign sel_port = (paddr[PADDR_W-1] == REG_SEL_LOCAL_PORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q <= '0;
		end else if (psel && penable && pwrite && sel_port) begin
			local_port_q <= pwdata[15:0];
		end
	end

	assign pready     = 1'b1;
	assign prdata     = sel_port ? {16'h0000, local_port_q} : 32'h0000_0000;
	assign local_port = local_port_q;

endmodule

`default_nettype wire

[rtl/ipv4rx_parse.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_parse
	import ipv4rx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire byte_item_t  item,
	input  wire logic [15:0] local_port,
	output verdict_t         verdict
);

	logic [POS_W-1:0] pos_q;
	logic [SUM_W-1:0] sum_q;
	logic [7:0]       hold_q;
	logic [3:0]       ihl_q;
	logic [7:0]       proto_q;
	logic [15:0]      csum_q;
	logic [15:0]      port_q;
	logic             port_done_q;

	logic [POS_W-1:0] pos_d;
	logic [SUM_W-1:0] sum_d;
	logic [7:0]       hold_d;
	logic [3:0]       ihl_d;
	logic [7:0]       proto_d;
	logic [15:0]      csum_d;
	logic [15:0]      port_d;
	logic             port_done_d;

	logic [POS_W-1:0] off;
	logic [POS_W-1:0] hlen;
	logic             in_ip;
	logic [16:0]      fold1;
	logic [15:0]      fold2;
	logic [15:0]      calc;

	assign in_ip = (pos_q >= POS_IP_START);
	assign off   = pos_q - POS_IP_START;
	assign hlen  = POS_W'({ihl_q, 2'b00});

	always_comb begin
		pos_d       = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
		sum_d       = sum_q;
		hold_d      = hold_q;
		ihl_d       = ihl_q;
		proto_d     = proto_q;
		csum_d      = csum_q;
		port_d      = port_q;
		port_done_d = port_done_q;
		if (in_ip) begin
			if (off == '0) begin
				ihl_d = item.data[3:0];
			end
			if (off == IP_OFF_PROTO) begin
				proto_d = item.data;
			end
			if (off == IP_OFF_CSUM_HI) begin
				csum_d[15:8] = item.data;
			end
			if (off == IP_OFF_CSUM_LO) begin
				csum_d[7:0] = item.data;
			end
			if (off < hlen || off == '0) begin
				if (!off[0]) begin
					hold_d = item.data;
				end else if (off != IP_OFF_CSUM_LO) begin
					sum_d = sum_q + SUM_W'({hold_q, item.data});
				end
			end
			if (off == hlen + PORT_OFF_HI) begin
				port_d[15:8] = item.data;
			end
			if (off == hlen + PORT_OFF_LO) begin
				port_d[7:0] = item.data;
				port_done_d = 1'b1;
			end
		end
	end

	assign fold1 = {1'b0, sum_d[15:0]} + 17'(sum_d[SUM_W-1:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);
	assign calc  = ~fold2;

	always_comb begin
		if (!port_done_d) begin
			verdict.reason = DROP_TOO_SHORT;
		end else if (calc != csum_d) begin
			verdict.reason = DROP_CHECKSUM;
		end else if (proto_d != PROTO_TCP) begin
			verdict.reason = DROP_NOT_TCP;
		end else if (port_d != local_port) begin
			verdict.reason = DROP_PORT;
		end else begin
			verdict.reason = DROP_NONE;
		end
		verdict.accepted = (verdict.reason == DROP_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sum_q       <= '0;
			hold_q      <= '0;
			ihl_q       <= '0;
			proto_q     <= '0;
			csum_q      <= '0;
			port_q      <= '0;
			port_done_q <= 1'b0;
		end else if (take) begin
			if (item.last) begin
				pos_q       <= '0;
				sum_q       <= '0;
				hold_q      <= '0;
				ihl_q       <= '0;
				proto_q     <= '0;
				csum_q      <= '0;
				port_q      <= '0;
				port_done_q <= 1'b0;
			end else begin
				pos_q       <= pos_d;
				sum_q       <= sum_d;
				hold_q      <= hold_d;
				ihl_q       <= ihl_d;
				proto_q     <= proto_d;
				csum_q      <= csum_d;
				port_q      <= port_d;
				port_done_q <= port_done_d;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/ipv4_rx_checksum_port_filter_top.sv]
// Channel   Signals                                     Moves
// -------   ------------------------------------------  ------------------------------
// byte      byte_valid/byte_ready, data_byte, last_byte  one frame byte per transfer
// verdict   verdict_valid/verdict_ready,                 one verdict per frame
//           frame_accepted, drop_reason
// config    APB: psel, penable, pwrite, paddr, pwdata    local_port at address 0
//
// One byte per cycle sustained unless a stalled verdict blocks a last byte;
// each byte passes through the input register. The verdict loads into the
// output register at the edge where the last byte leaves the input register.
// A stalled verdict holds the next last byte in the input register and stops
// the byte channel behind it; bytes ahead of that last byte keep flowing.
// arst_n clears the frame state, local_port and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_rx_checksum_port_filter_top
	import ipv4rx_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               byte_valid,
	output logic                    byte_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	output logic                    verdict_valid,
	input  wire logic               verdict_ready,
	output logic                    frame_accepted,
	output logic      [2:0]         drop_reason
);

	logic [15:0] local_port;
	byte_item_t  item_s1;
	logic        valid_s1;
	verdict_t    verdict;
	verdict_t    verdict_s2;
	logic        valid_s2;
	logic        out_free;
	logic        take_s1;

	ipv4rx_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.local_port (local_port)
	);

	assign out_free   = !valid_s2 || verdict_ready;
	assign take_s1    = valid_s1 && (!item_s1.last || out_free);
	assign byte_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1.data <= data_byte;
			item_s1.last <= last_byte;
		end
	end

	ipv4rx_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take_s1),
		.item       (item_s1),
		.local_port (local_port),
		.verdict    (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= take_s1 && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && take_s1 && item_s1.last) begin
			verdict_s2 <= verdict;
		end
	end

	assign verdict_valid  = valid_s2;
	assign frame_accepted = verdict_s2.accepted;
	assign drop_reason    = verdict_s2.reason;

`ifndef SYNTHESIS
	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(take_s1 && item_s1.last))
		else $error("verdict without a last byte");

	a_accept_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (frame_accepted == (drop_reason == DROP_NONE)))
		else $error("accept flag disagrees with drop reason");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (valid_s1 && item_s1.last && valid_s2 && !verdict_ready))
		else $error("byte channel stalled without a blocked verdict");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import ipv4rx_pkg::*;

	localparam logic [PADDR_W-1:0] LOCAL_PORT_ADDR = '0;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int BYTE_TARGET = 1950;

	typedef struct {
		int         new_port;
		logic [3:0] ihl;
		logic [7:0] proto;
		logic [15:0] dport;
		bit         csum_good;
		int         payload;
		int         cut_len;
		int         fill;
		bit         typed;
		logic [2:0] want;
	} frame_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              byte_valid = 1'b0;
	logic              byte_ready;
	logic [7:0]        data_byte = '0;
	logic              last_byte = 1'b0;
	logic              verdict_valid;
	logic              verdict_ready = 1'b0;
	logic              frame_accepted;
	logic [2:0]        drop_reason;

	ipv4_rx_checksum_port_filter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.frame_accepted(frame_accepted),
		.drop_reason   (drop_reason)
	);

	// frame tracking state
	logic [POS_W-1:0] rx_pos;
	logic [SUM_W-1:0] hdr_sum;
	logic [7:0]       hi_byte;
	logic [3:0]       ihl_words;
	logic [7:0]       proto_seen;
	logic [15:0]      csum_seen;
	logic [15:0]      dport_seen;
	logic             dport_done;
	logic [15:0]      local_port_cfg;

	verdict_t   pending_verdicts[$];
	logic [7:0] wire_bytes[$];
	int         errors = 0;
	int         bytes_sent = 0;
	int         verdicts_seen = 0;
	bit         hold_verdicts = 0;

	frame_row_t directed_frames [16] = '{
		'{-1, 4'd5, PROTO_TCP, 16'h0000, 1, 0, 1, 0, 1, DROP_TOO_SHORT},
		'{-1, 4'd5, PROTO_TCP, 16'h0000, 1, 0, 1, 255, 1, DROP_TOO_SHORT},
		'{-1, 4'd5, PROTO_TCP, 16'h0000, 1, 0, 0, 255, 1, DROP_NONE},
		'{-1, 4'd5, PROTO_TCP, 16'h1234, 1, 0, 0, 0, 1, DROP_PORT},
		'{-1, 4'd5, 8'd17, 16'h0000, 1, 0, 0, -1, 1, DROP_NOT_TCP},
		'{-1, 4'd5, 8'd17, 16'h1234, 0, 4, 0, -1, 1, DROP_CHECKSUM},
		'{-1, 4'd5, PROTO_TCP, 16'h0000, 0, 0, 37, -1, 1, DROP_TOO_SHORT},
		'{-1, 4'd15, PROTO_TCP, 16'h0000, 1, 6, 0, -1, 1, DROP_NONE},
		'{-1, 4'd0, PROTO_TCP, 16'h0000, 1, 2, 0, -1, 0, DROP_NONE},
		'{-1, 4'd1, PROTO_TCP, 16'h0000, 1, 2, 0, -1, 0, DROP_NONE},
		'{-1, 4'd2, PROTO_TCP, 16'h0000, 1, 2, 0, -1, 0, DROP_NONE},
		'{-1, 4'd4, PROTO_TCP, 16'h0000, 1, 2, 0, -1, 0, DROP_NONE},
		'{-1, 4'd5, PROTO_TCP, 16'h0000, 1, 120, 0, -1, 1, DROP_NONE},
		'{16'hffff, 4'd5, PROTO_TCP, 16'hffff, 1, 0, 0, -1, 1, DROP_NONE},
		'{-1, 4'd5, PROTO_TCP, 16'hfffe, 1, 0, 0, -1, 1, DROP_PORT},
		'{0, 4'd5, PROTO_TCP, 16'h0000, 1, 0, 0, -1, 1, DROP_NONE}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_frame_state();
		rx_pos = '0;
		hdr_sum = '0;
		hi_byte = '0;
		ihl_words = '0;
		proto_seen = '0;
		csum_seen = '0;
		dport_seen = '0;
		dport_done = 1'b0;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		int unsigned off;
		int unsigned hlen;
		if (rx_pos >= POS_IP_START) begin
			off = rx_pos - POS_IP_START;
			hlen = ihl_words * 4;
			if (off == 0)
				ihl_words = b[3:0];
			if (off == IP_OFF_PROTO)
				proto_seen = b;
			if (off == IP_OFF_CSUM_HI)
				csum_seen[15:8] = b;
			if (off == IP_OFF_CSUM_LO)
				csum_seen[7:0] = b;
			if (off < hlen || off == 0) begin
				if (off[0] == 1'b0)
					hi_byte = b;
				else if (off != IP_OFF_CSUM_LO)
					hdr_sum = hdr_sum + SUM_W'({hi_byte, b});
			end
			if (off == hlen + PORT_OFF_HI)
				dport_seen[15:8] = b;
			if (off == hlen + PORT_OFF_LO) begin
				dport_seen[7:0] = b;
				dport_done = 1'b1;
			end
		end
		if (rx_pos != POS_MAX)
			rx_pos = rx_pos + 1'b1;
	endfunction

	function automatic logic [2:0] judge_frame();
		logic [16:0] folded;
		logic [15:0] calc;
		if (!dport_done)
			return DROP_TOO_SHORT;
		folded = 17'(hdr_sum[SUM_W-1:16]) + 17'(hdr_sum[15:0]);
		folded = folded + 17'(folded[16]);
		calc = ~folded[15:0];
		if (calc != csum_seen)
			return DROP_CHECKSUM;
		if (proto_seen != PROTO_TCP)
			return DROP_NOT_TCP;
		if (dport_seen != local_port_cfg)
			return DROP_PORT;
		return DROP_NONE;
	endfunction

	function automatic logic [7:0] fill_byte(input int fill);
		return (fill < 0) ? 8'($urandom) : 8'(fill);
	endfunction

	task automatic build_ip_frame(input logic [3:0] ihl, input logic [7:0] proto,
			input logic [15:0] dport, input bit csum_good, input int payload,
			input int cut_len, input int fill);
		int hdr_len;
		int ip_len;
		logic [7:0] ip[$];
		logic [31:0] acc;
		wire_bytes.delete();
		hdr_len = ihl * 4;
		ip_len = ((hdr_len + 4 > 12) ? hdr_len + 4 : 12) + payload;
		for (int i = 0; i < LINK_HEADER_BYTES; i++)
			wire_bytes.push_back(fill_byte(fill));
		for (int i = 0; i < ip_len; i++)
			ip.push_back(fill_byte(fill));
		ip[0][3:0] = ihl;
		ip[IP_OFF_PROTO] = proto;
		ip[IP_OFF_CSUM_HI] = 8'h00;
		ip[IP_OFF_CSUM_LO] = 8'h00;
		acc = '0;
		for (int i = 0; i < hdr_len; i += 2)
			acc = acc + {16'h0, ip[i], ip[i+1]};
		while (acc[31:16] != 0)
			acc = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
		{ip[IP_OFF_CSUM_HI], ip[IP_OFF_CSUM_LO]} = ~acc[15:0] ^
			(csum_good ? 16'h0000 : 16'($urandom_range(1, 65535)));
		{ip[hdr_len + PORT_OFF_HI], ip[hdr_len + PORT_OFF_LO]} = dport;
		foreach (ip[i])
			wire_bytes.push_back(ip[i]);
		if (cut_len < 0)
			cut_len = $urandom_range(1, wire_bytes.size() - 1);
		if (cut_len > 0 && cut_len < wire_bytes.size())
			wire_bytes = wire_bytes[0:cut_len-1];
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input logic [2:0] want, input bit eager);
		int gap;
		verdict_t exp_verdict;
		gap = eager ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		bytes_sent++;
		absorb_byte(b);
		if (last) begin
			exp_verdict.reason = typed ? want : judge_frame();
			exp_verdict.accepted = (exp_verdict.reason == DROP_NONE);
			pending_verdicts.push_back(exp_verdict);
			clear_frame_state();
		end
	endtask

	task automatic send_frame(input bit typed, input logic [2:0] want);
		bit eager;
		eager = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < wire_bytes.size(); i++)
			send_byte(wire_bytes[i], i == wire_bytes.size() - 1, typed, want, eager);
	endtask

	task automatic settle();
		byte_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_local_port(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LOCAL_PORT_ADDR;
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		local_port_cfg = value;
	endtask

	task automatic random_frame();
		logic [3:0] ihl;
		logic [7:0] proto;
		logic [15:0] dport;
		bit good;
		int payload;
		if ($urandom_range(0, 9) < 8) begin
			ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4)) :
				4'($urandom_range(5, 15));
			proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_TCP;
			dport = ($urandom_range(0, 4) == 0) ? 16'($urandom) : local_port_cfg;
			good = ($urandom_range(0, 6) != 0);
			payload = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 110) :
				$urandom_range(0, 8);
			build_ip_frame(ihl, proto, dport, good, payload,
				($urandom_range(0, 9) == 0) ? -1 : 0, -1);
		end else begin
			wire_bytes.delete();
			repeat ($urandom_range(1, 60))
				wire_bytes.push_back(8'($urandom));
		end
		send_frame(1'b0, DROP_NONE);
	endtask

	// verdict sink
	initial begin : verdict_sink
		int gap;
		verdict_t got;
		verdict_t want;
		@(posedge arst_n);
		forever begin
			gap = ((verdicts_seen / 16) % 2 == 1) ? 0 : $urandom_range(0, 7);
			if (hold_verdicts) begin
				verdict_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_verdicts = 0;
			end else if (gap > 0) begin
				verdict_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			verdict_ready <= 1'b1;
			@(posedge clk);
			while (!verdict_valid) @(posedge clk);
			verdicts_seen++;
			got.accepted = frame_accepted;
			got.reason = drop_reason;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict accepted=%0b reason=%0d", $time,
					got.accepted, got.reason);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.accepted !== want.accepted) begin
					$display("%0t: frame_accepted expected %0b actual %0b", $time,
						want.accepted, got.accepted);
					errors++;
				end
				if (got.reason !== want.reason) begin
					$display("%0t: drop_reason expected %0d actual %0d", $time,
						want.reason, got.reason);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && byte_ready) || (verdict_valid && verdict_ready) ||
					(psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int frames;
		int r;
		local_port_cfg = '0;
		clear_frame_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_frames[i]) begin
			if (directed_frames[i].new_port >= 0) begin
				settle();
				write_local_port(16'(directed_frames[i].new_port));
			end
			build_ip_frame(directed_frames[i].ihl, directed_frames[i].proto,
				directed_frames[i].dport, directed_frames[i].csum_good,
				directed_frames[i].payload, directed_frames[i].cut_len,
				directed_frames[i].fill);
			send_frame(directed_frames[i].typed, directed_frames[i].want);
		end

		frames = 0;
		while (bytes_sent < BYTE_TARGET) begin
			if (frames % 8 == 0) begin
				settle();
				r = $urandom_range(0, 3);
				write_local_port((r == 0) ? 16'h0000 : (r == 1) ? 16'hffff :
					16'($urandom));
			end
			// long receiver stall: the next last byte must back up
			if (frames == 5)
				hold_verdicts = 1;
			random_frame();
			frames++;
		end

		settle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
